// ===== sv/tes_pkg.sv =====
//------------------------------------------------------------------------------
// tes_pkg
// shared types and codes for the timeline event scheduler
//------------------------------------------------------------------------------
`default_nettype none
package tes_pkg;

	// table depth; entry_index is four bits wide
	localparam int ENTRIES = 16;

	typedef enum logic [3:0] {
		MODE_TICK      = 4'd0,
		MODE_PLAY      = 4'd1,
		MODE_STOP      = 4'd2,
		MODE_PAUSE     = 4'd3,
		MODE_RESUME    = 4'd4,
		MODE_SET_FRAME = 4'd5,
		MODE_APPEND    = 4'd6,
		MODE_REM_IDX   = 4'd7,
		MODE_RET_IDX   = 4'd8,
		MODE_REM_TAG   = 4'd9,
		MODE_RET_TAG   = 4'd10,
		MODE_CLEAR     = 4'd11
	} mode_t;

	typedef enum logic [2:0] {
		REG_MIN_FRAME = 3'd0,
		REG_MAX_FRAME = 3'd1,
		REG_COUNT_EN  = 3'd2,
		REG_LOOP_EN   = 3'd3,
		REG_NOTIFY_DIS = 3'd4,
		REG_ACTIVE    = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_FIND,
		ST_REMOVE,
		ST_INSERT,
		ST_SCAN1,
		ST_SCAN2,
		ST_WRAP,
		ST_STATUS,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic min_frame_set;
		logic max_frame_set;
		logic count_enable;
		logic loop_enable;
		logic notify_disable;
		logic active;
	} cfg_flags_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input beat
		logic prep;       // apply simple mode effects, start scan index
		logic find_step;  // advance find index
		logic rem_step;   // one shift step of removal
		logic ins_step;   // one shift step of insertion
		logic scan_step;  // one step of event scan
		logic scan2_start;
		logic wrap;       // end-of-tick update
		logic emit_status;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [3:0] mode;
		logic       tick_run;   // tick passes range/active check
		logic       do_scan;    // window scanning needed
		logic       two_win;
		logic       find_done;
		logic       find_hit;
		logic       rem_done;
		logic       ins_done;
		logic       scan_done;
		logic       ev_valid;
		logic       bad;        // index/full/unknown-mode failure
		logic       out_busy;   // output register holds a beat not taken this cycle
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== sv/tes_if.sv =====
//------------------------------------------------------------------------------
// tes_in_if / tes_out_if
// valid/ready channels for input items and result items
//------------------------------------------------------------------------------
`default_nettype none
interface tes_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  mode;
	logic [30:0] delta;
	logic signed [31:0] new_frame;
	logic        skip_events;
	logic [3:0]  entry_index;
	logic signed [31:0] entry_time;
	logic [15:0] entry_tag;
	modport source (output valid, mode, delta, new_frame, skip_events, entry_index,
		entry_time, entry_tag, input ready);
	modport sink (input valid, mode, delta, new_frame, skip_events, entry_index,
		entry_time, entry_tag, output ready);
endinterface

interface tes_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] fired_tag;
	logic signed [31:0] fired_time;
	logic        ok;
	logic signed [31:0] current_frame;
	logic        playing;
	logic        last;
	modport source (output valid, kind, fired_tag, fired_time, ok, current_frame,
		playing, last, input ready);
	modport sink (input valid, kind, fired_tag, fired_time, ok, current_frame,
		playing, last, output ready);
endinterface
`default_nettype wire

// ===== sv/tes_ctrl.sv =====
//------------------------------------------------------------------------------
// tes_ctrl
// sequencer for one input item: edit table, scan windows, send status
//------------------------------------------------------------------------------
`default_nettype none
module tes_ctrl import tes_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PREP;
			ST_PREP: begin
				priority if (sts.bad) state_d = ST_STATUS;
				else if (sts.mode == MODE_TICK) state_d = sts.do_scan ? ST_SCAN1 : ST_WRAP;
				else if (sts.mode == MODE_APPEND) state_d = ST_INSERT;
				else if (sts.mode == MODE_REM_IDX || sts.mode == MODE_RET_IDX)
					state_d = ST_REMOVE;
				else if (sts.mode == MODE_REM_TAG || sts.mode == MODE_RET_TAG)
					state_d = ST_FIND;
				else state_d = ST_STATUS;
			end
			ST_FIND: if (sts.find_done) state_d = sts.find_hit ? ST_REMOVE : ST_STATUS;
			ST_REMOVE: if (sts.rem_done) begin
				state_d = (sts.mode == MODE_RET_IDX || sts.mode == MODE_RET_TAG)
					? ST_INSERT : ST_STATUS;
			end
			ST_INSERT: if (sts.ins_done) state_d = ST_STATUS;
			ST_SCAN1: if (!sts.out_busy && sts.scan_done)
				state_d = sts.two_win ? ST_SCAN2 : ST_WRAP;
			ST_SCAN2: if (!sts.out_busy && sts.scan_done) state_d = ST_WRAP;
			ST_WRAP: state_d = ST_STATUS;
			ST_STATUS: if (!sts.out_busy) state_d = ST_WAIT;
			ST_WAIT: if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_PREP: cmd.prep = 1'b1;
			ST_FIND: cmd.find_step = 1'b1;
			ST_REMOVE: cmd.rem_step = 1'b1;
			ST_INSERT: cmd.ins_step = 1'b1;
			ST_SCAN1: begin
				cmd.scan_step = !sts.out_busy;
				cmd.scan2_start = !sts.out_busy && sts.scan_done && sts.two_win;
			end
			ST_SCAN2: cmd.scan_step = !sts.out_busy;
			ST_WRAP: cmd.wrap = 1'b1;
			ST_STATUS: cmd.emit_status = !sts.out_busy;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_status |-> !sts.out_busy)
		else $error("status overwrote pending beat");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !sts.out_busy)
		else $error("scan stepped while output full");
`endif

endmodule
`default_nettype wire

// ===== sv/tes_dp.sv =====
//------------------------------------------------------------------------------
// tes_dp
// datapath: config, playhead, sorted event table, output register
//------------------------------------------------------------------------------
`default_nettype none
module tes_dp import tes_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [31:0] cfg_data,
	output logic [31:0]  cfg_rdata,
	input  wire logic [2:0] cfg_ridx,
	input  wire logic    in_rdy,
	tes_in_if.sink       in_ch,
	tes_out_if.source    out_ch,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(ENTRIES);
	localparam logic signed [32:0] I32MAX = 33'sd2147483647;

	logic signed [31:0] min_q, max_q;
	logic count_en_q, loop_en_q, notify_dis_q, active_q;

	logic signed [31:0] times_q [ENTRIES];
	logic [15:0]        tags_q [ENTRIES];
	logic [CW-1:0]      count_q;
	logic signed [31:0] head_q, prev_q;
	logic               playing_q;

	// captured beat
	logic [3:0]  mode_q;
	logic [30:0] delta_q;
	logic signed [31:0] nf_q, et_q;
	logic        skip_q;
	logic [3:0]  idx_q;
	logic [15:0] tag_q;
	logic        ok_q;

	// work registers
	logic [CW-1:0] ptr_q;      // scan / find / shift position
	logic [CW-1:0] rem_idx_q;  // original index for retime ties
	logic [15:0]   mv_tag_q;
	logic signed [31:0] ws_q, we_q, w2s_q, w2e_q;
	logic          two_q, wrap_pending_q;
	logic signed [31:0] wprev_q;
	logic [CW-1:0] nev_q;

	// output register
	logic        ov_q;
	logic        okind_q, ook_q, olast_q;
	logic [15:0] otag_q;
	logic signed [31:0] otime_q;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0; max_q <= '0;
			count_en_q <= 1'b0; loop_en_q <= 1'b0;
			notify_dis_q <= 1'b0; active_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_FRAME: min_q <= cfg_data;
				REG_MAX_FRAME: max_q <= cfg_data;
				REG_COUNT_EN:  count_en_q <= cfg_data[0];
				REG_LOOP_EN:   loop_en_q <= cfg_data[0];
				REG_NOTIFY_DIS: notify_dis_q <= cfg_data[0];
				REG_ACTIVE:    active_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_ridx)
			REG_MIN_FRAME: cfg_rdata = min_q;
			REG_MAX_FRAME: cfg_rdata = max_q;
			REG_COUNT_EN:  cfg_rdata = {31'd0, count_en_q};
			REG_LOOP_EN:   cfg_rdata = {31'd0, loop_en_q};
			REG_NOTIFY_DIS: cfg_rdata = {31'd0, notify_dis_q};
			REG_ACTIVE:    cfg_rdata = {31'd0, active_q};
			default:       cfg_rdata = '0;
		endcase
	end

	// tick arithmetic for prep
	logic signed [32:0] sum;
	logic signed [31:0] adv, adv_cl;
	logic tick_ok, counting;
	assign tick_ok = (max_q >= min_q) && active_q;
	assign counting = playing_q && count_en_q;
	assign sum = 33'(head_q) + $signed({2'b00, delta_q});
	assign adv = (sum > I32MAX) ? 32'sh7fffffff : sum[31:0];
	assign adv_cl = (adv < min_q) ? min_q : adv;

	logic signed [31:0] new_head;
	assign new_head = counting ? adv_cl : head_q;

	// end-of-range handling is settled at prep so every beat shows the final playhead
	logic wrap_hit;
	logic signed [31:0] head_fin, prev_fin;
	assign wrap_hit = counting && (new_head >= max_q);
	assign head_fin = !wrap_hit ? new_head
		: loop_en_q ? new_head + (min_q - max_q) : max_q;
	assign prev_fin = (wrap_hit && !loop_en_q) ? max_q : new_head;

	logic signed [31:0] nf_cl;
	assign nf_cl = (nf_q < min_q) ? min_q : nf_q;

	logic [IW-1:0] p;
	assign p = ptr_q[IW-1:0];
	logic in_range;
	assign in_range = ptr_q < count_q;

	// scan window compare at ptr
	logic signed [31:0] cur_t;
	assign cur_t = times_q[p];
	logic below, above;
	assign below = cur_t < ws_q;
	assign above = cur_t > we_q;
	logic scan_emit, scan_end;
	assign scan_end = !in_range || above || (ws_q >= we_q) || notify_dis_q
		|| (nev_q == FULL);
	assign scan_emit = !scan_end && !below;

	// insertion: step from top down; ptr is the hole position
	logic [IW-1:0] pm1;
	assign pm1 = IW'(ptr_q - CW'(1));
	logic ins_shift;
	// shift when the element below the hole must go above the new time
	logic signed [31:0] prev_t;
	assign prev_t = times_q[pm1];
	always_comb begin
		ins_shift = 1'b0;
		if (ptr_q != '0) begin
			if (mode_q == MODE_APPEND) ins_shift = prev_t > et_q;
			else ins_shift = (prev_t > et_q) || (prev_t == et_q && ptr_q > rem_idx_q);
		end
	end

	logic bad;
	always_comb begin
		bad = 1'b0;
		unique case (mode_q)
			MODE_APPEND: bad = count_q >= FULL;
			MODE_REM_IDX, MODE_RET_IDX: bad = CW'(idx_q) >= count_q;
			default: bad = 1'b0;
		endcase
		if (mode_q > MODE_CLEAR) bad = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; head_q <= '0; prev_q <= '0; playing_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if ((cmd.scan_step && scan_emit) || cmd.emit_status) ov_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			if (cmd.prep) begin
				unique case (mode_q)
					MODE_PLAY, MODE_STOP: begin
						playing_q <= (mode_q == MODE_PLAY);
						head_q <= min_q; prev_q <= min_q;
					end
					MODE_PAUSE: playing_q <= 1'b0;
					MODE_RESUME: playing_q <= 1'b1;
					MODE_SET_FRAME: begin
						head_q <= nf_cl;
						if (skip_q || !active_q) prev_q <= nf_cl;
					end
					MODE_CLEAR: count_q <= '0;
					MODE_TICK: if (tick_ok) begin
						head_q <= head_fin;
						if (wrap_hit && !loop_en_q) playing_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.rem_step && !(ptr_q + CW'(1) < count_q)) count_q <= count_q - CW'(1);
			if (cmd.ins_step && !ins_shift) count_q <= count_q + CW'(1);
			if (cmd.wrap && wrap_pending_q) prev_q <= wprev_q;
		end
	end

	// table and work registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_ch.mode; delta_q <= in_ch.delta; nf_q <= in_ch.new_frame;
			skip_q <= in_ch.skip_events; idx_q <= in_ch.entry_index;
			et_q <= in_ch.entry_time; tag_q <= in_ch.entry_tag;
		end
		if (cmd.prep) begin
			ok_q <= !bad;
			nev_q <= '0;
			wrap_pending_q <= (mode_q == MODE_TICK) && tick_ok;
			wprev_q <= prev_fin;
			unique case (mode_q)
				MODE_APPEND: ptr_q <= count_q;
				MODE_REM_IDX, MODE_RET_IDX: begin
					ptr_q <= CW'(idx_q); rem_idx_q <= CW'(idx_q);
					mv_tag_q <= tags_q[idx_q[IW-1:0]];
				end
				default: ptr_q <= '0;
			endcase
			if (new_head < prev_q) begin
				ws_q <= prev_q; we_q <= max_q;
				w2s_q <= min_q; w2e_q <= new_head; two_q <= 1'b1;
			end else begin
				ws_q <= prev_q; we_q <= new_head; two_q <= 1'b0;
				w2s_q <= min_q; w2e_q <= new_head;
			end
		end
		if (cmd.find_step) begin
			if (in_range && tags_q[p] == tag_q) begin
				rem_idx_q <= ptr_q; mv_tag_q <= tags_q[p];
			end else ptr_q <= ptr_q + CW'(1);
			if (!in_range) ok_q <= 1'b0;
		end
		if (cmd.rem_step) begin
			if (ptr_q + CW'(1) < count_q) begin
				times_q[p] <= times_q[IW'(ptr_q + CW'(1))];
				tags_q[p] <= tags_q[IW'(ptr_q + CW'(1))];
				ptr_q <= ptr_q + CW'(1);
			end else ptr_q <= count_q - CW'(1);
		end
		if (cmd.ins_step) begin
			if (ins_shift) begin
				times_q[p] <= prev_t; tags_q[p] <= tags_q[pm1];
				ptr_q <= ptr_q - CW'(1);
			end else begin
				times_q[p] <= et_q;
				tags_q[p] <= (mode_q == MODE_APPEND) ? tag_q : mv_tag_q;
			end
		end
		if (cmd.scan_step) begin
			if (scan_emit) begin
				okind_q <= 1'b0; otag_q <= tags_q[p]; otime_q <= cur_t;
				ook_q <= 1'b1; olast_q <= 1'b0;
				nev_q <= nev_q + CW'(1);
			end
			if (!scan_end) ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.scan2_start) begin
			ws_q <= w2s_q; we_q <= w2e_q; ptr_q <= '0;
		end
		if (cmd.emit_status) begin
			okind_q <= 1'b1; otag_q <= '0; otime_q <= '0; ook_q <= ok_q; olast_q <= 1'b1;
		end
	end

	// find terminates on a hit (ptr holds) or when out of range
	logic find_hit;
	assign find_hit = in_range && tags_q[p] == tag_q;

	assign in_ch.ready = in_rdy;
	always_comb begin
		sts.mode = mode_q;
		sts.tick_run = tick_ok;
		sts.do_scan = (mode_q == MODE_TICK) && tick_ok && (new_head != prev_q);
		sts.two_win = two_q;
		sts.find_done = !in_range || find_hit;
		sts.find_hit = find_hit;
		sts.rem_done = !(ptr_q + CW'(1) < count_q);
		sts.ins_done = !ins_shift;
		sts.scan_done = scan_end;
		sts.ev_valid = scan_emit;
		sts.bad = bad;
		sts.out_busy = ov_q && !out_ch.ready;
	end

	assign out_ch.valid = ov_q;
	assign out_ch.kind = okind_q;
	assign out_ch.fired_tag = otag_q;
	assign out_ch.fired_time = otime_q;
	assign out_ch.ok = ook_q;
	assign out_ch.current_frame = head_q;
	assign out_ch.playing = playing_q;
	assign out_ch.last = olast_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count beyond table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |=> ov_q)
		else $error("result beat dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && scan_emit) |-> (nev_q < FULL))
		else $error("too many events");
`endif

endmodule
`default_nettype wire

// ===== sv/timeline_event_scheduler.sv =====
// table edits walk the table one entry a cycle
// a tick scans the table one entry a cycle per window, stalling on result back-pressure
// one item at a time; the next input is taken after the status beat leaves
// arst_n clears config to reset values, the entry count, playhead and play state
//------------------------------------------------------------------------------
// timeline_event_scheduler
// playhead with a sorted event table and APB configuration
//------------------------------------------------------------------------------
`default_nettype none
module timeline_event_scheduler import tes_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	tes_in_if.sink           in_ch,
	tes_out_if.source        out_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic ready;
	logic cfg_we;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'b00);
	assign ridx = paddr[4:2];

	tes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(ready),
		.sts(sts), .cmd(cmd)
	);

	tes_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(paddr[4:2]),
		.cfg_data(pwdata), .cfg_rdata(prdata), .cfg_ridx(ridx), .in_rdy(ready),
		.in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .sts(sts)
	);

endmodule
`default_nettype wire
